// ----- hw/rtl/cppc_pkg.sv -----
// ----------------------------------------------------------------------------
// cppc_pkg
// shared constants, codes and types of the convex polygon point classifier
// ----------------------------------------------------------------------------
package cppc_pkg;

  // store and coordinate sizing
  localparam int MAX_EDGES    = 16;
  localparam int COORD_BITS   = 16;

  // fixed port widths
  localparam int FIELD_W      = 16;
  localparam int CMD_W        = 2;
  localparam int PLACE_W      = 2;
  localparam int EDGES_HELD_W = 5;

  // derived widths
  localparam int IDX_W        = $clog2(MAX_EDGES);
  localparam int COUNT_W      = $clog2(MAX_EDGES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int ENTRY_W      = 4 * COORD_BITS;

  // read, subtract, multiply stages ahead of the compare
  localparam int PIPE_LAT     = 3;
  localparam int DRAIN_W      = $clog2(PIPE_LAT);

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

  // placement codes
  localparam logic [PLACE_W-1:0] PLACE_OUTSIDE = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_ON      = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_INSIDE  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             accept;
    logic             classify;
    logic             set_full;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
  } ctl_cmd_t;

  function automatic diff_t sext(input coord_t v);
    return diff_t'(v);
  endfunction

endpackage

// ----- hw/rtl/convex_polygon_point_classify.sv -----
// ----------------------------------------------------------------------------
// convex_polygon_point_classify
// point in convex polygon test against a store of directed edges
// ----------------------------------------------------------------------------
// a command is taken when start is high and busy is low; its result sits on
// placement, store_full and edges_held for exactly one cycle with done high,
// and there is no way to hold it off. clear, append and unknown commands give
// their result in the cycle after the transfer and a new command may be taken
// in that same cycle, so they run at one per cycle. a classify with edges
// stored gives done after the walk and the pipeline drain (with none stored,
// in the cycle after the transfer): the edges are read back from last to
// first, one per cycle, through a three stage read, subtract and multiply
// pipeline, and the walk always runs to the first edge even when an earlier
// edge has already decided. busy stays high in the walk and pipeline drain.
// ----------------------------------------------------------------------------
module convex_polygon_point_classify (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [cppc_pkg::CMD_W-1:0]          command,
  input  logic signed [cppc_pkg::FIELD_W-1:0] edge_start_x,
  input  logic signed [cppc_pkg::FIELD_W-1:0] edge_start_y,
  input  logic signed [cppc_pkg::FIELD_W-1:0] edge_end_x,
  input  logic signed [cppc_pkg::FIELD_W-1:0] edge_end_y,
  input  logic signed [cppc_pkg::FIELD_W-1:0] point_x,
  input  logic signed [cppc_pkg::FIELD_W-1:0] point_y,
  output logic                                done,
  output logic [cppc_pkg::PLACE_W-1:0]        placement,
  output logic                                store_full,
  output logic [cppc_pkg::EDGES_HELD_W-1:0]   edges_held
);

  import cppc_pkg::*;

  // command bundle from sequencer to datapath
  ctl_cmd_t cmd;

  // sequencer: owns the edge count, the walk index and the result strobe
  cppc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .busy       (busy),
    .done       (done),
    .edges_held (edges_held),
    .cmd        (cmd)
  );

  // datapath: edge store, cross products and the first-hit decision
  cppc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .edge_start_x (edge_start_x),
    .edge_start_y (edge_start_y),
    .edge_end_x   (edge_end_x),
    .edge_end_y   (edge_end_y),
    .point_x      (point_x),
    .point_y      (point_y),
    .placement    (placement),
    .store_full   (store_full)
  );

endmodule

// ----- hw/rtl/cppc_ram.sv -----
// ----------------------------------------------------------------------------
// cppc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/cppc_dp.sv -----
// ----------------------------------------------------------------------------
// cppc_dp
// edge store, cross product pipeline and result registers
// ----------------------------------------------------------------------------
module cppc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cppc_pkg::ctl_cmd_t                   cmd,
  input  logic signed [cppc_pkg::FIELD_W-1:0]  edge_start_x,
  input  logic signed [cppc_pkg::FIELD_W-1:0]  edge_start_y,
  input  logic signed [cppc_pkg::FIELD_W-1:0]  edge_end_x,
  input  logic signed [cppc_pkg::FIELD_W-1:0]  edge_end_y,
  input  logic signed [cppc_pkg::FIELD_W-1:0]  point_x,
  input  logic signed [cppc_pkg::FIELD_W-1:0]  point_y,
  output logic [cppc_pkg::PLACE_W-1:0]         placement,
  output logic                                 store_full
);

  import cppc_pkg::*;

  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  coord_t             px;
  coord_t             py;
  coord_t             sx;
  coord_t             sy;
  coord_t             ex;
  coord_t             ey;
  diff_t              dyp;
  diff_t              dxe;
  diff_t              dxp;
  diff_t              dye;
  prod_t              lhs;
  prod_t              rhs;
  logic               v1;
  logic               v2;
  logic               v3;
  logic               decided;

  // the low COORD_BITS bits of each field are stored, here the whole field
  assign wr_data = {edge_start_x[COORD_BITS-1:0], edge_start_y[COORD_BITS-1:0],
                    edge_end_x[COORD_BITS-1:0], edge_end_y[COORD_BITS-1:0]};

  cppc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (cmd.addr),
    .rdata (rd_data)
  );

  assign sx = rd_data[4*COORD_BITS-1:3*COORD_BITS];
  assign sy = rd_data[3*COORD_BITS-1:2*COORD_BITS];
  assign ex = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign ey = rd_data[COORD_BITS-1:0];

  // query point
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px <= point_x[COORD_BITS-1:0];
      py <= point_y[COORD_BITS-1:0];
    end
  end

  // differences, then products
  always_ff @(posedge clk) begin
    dyp <= sext(py) - sext(sy);
    dxe <= sext(ex) - sext(sx);
    dxp <= sext(px) - sext(sx);
    dye <= sext(ey) - sext(sy);
    lhs <= dyp * dxe;
    rhs <= dxp * dye;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // first deciding edge wins, the rest of the walk drains unused
  always_ff @(posedge clk) begin
    if (rst) begin
      decided    <= 1'b0;
      placement  <= PLACE_OUTSIDE;
      store_full <= 1'b0;
    end else if (cmd.accept) begin
      decided    <= 1'b0;
      placement  <= cmd.classify ? PLACE_INSIDE : PLACE_OUTSIDE;
      store_full <= cmd.set_full;
    end else if (v3 && !decided) begin
      if (lhs == rhs) begin
        decided   <= 1'b1;
        placement <= PLACE_ON;
      end else if (lhs > rhs) begin
        decided   <= 1'b1;
        placement <= PLACE_OUTSIDE;
      end
    end
  end

endmodule

// ----- hw/rtl/cppc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cppc_ctrl
// command sequencer: edge count, store walk and result strobe
// ----------------------------------------------------------------------------
module cppc_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cppc_pkg::CMD_W-1:0]        command,
  output logic                              busy,
  output logic                              done,
  output logic [cppc_pkg::EDGES_HELD_W-1:0] edges_held,
  output cppc_pkg::ctl_cmd_t                cmd
);

  import cppc_pkg::*;

  ctl_state_t         state;
  ctl_state_t         state_next;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   idx;
  logic [DRAIN_W-1:0] drain;
  logic               accept;
  logic               is_full;
  logic               walk;

  assign busy    = (state == ST_WALK) || (state == ST_DRAIN);
  assign accept  = start && !busy;
  assign is_full = (count == COUNT_W'(MAX_EDGES));
  assign walk    = accept && (command == CMD_CLASSIFY) && (count != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_next = walk ? ST_WALK : ST_DONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (idx == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain == '0) begin
          state_next = ST_DONE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (command)
          CMD_CLEAR: count <= '0;
          CMD_APPEND: begin
            if (!is_full) begin
              count <= count + 1'b1;
            end
          end
          CMD_CLASSIFY: begin
            if (walk) begin
              idx <= IDX_W'(count - 1'b1);
            end
          end
          default: ;
        endcase
      end else if (state == ST_WALK) begin
        idx <= idx - 1'b1;
        if (idx == '0) begin
          drain <= DRAIN_W'(PIPE_LAT - 1);
        end
      end else if (state == ST_DRAIN) begin
        drain <= drain - 1'b1;
      end
    end
  end

  // outputs
  always_comb begin
    cmd.accept   = accept;
    cmd.classify = accept && (command == CMD_CLASSIFY);
    cmd.set_full = accept && (command == CMD_APPEND) && is_full;
    cmd.wr_en    = accept && (command == CMD_APPEND) && !is_full;
    cmd.rd_en    = (state == ST_WALK);
    cmd.addr     = (state == ST_WALK) ? idx : count[IDX_W-1:0];
    done         = (state == ST_DONE);
    edges_held   = EDGES_HELD_W'(count);
  end

endmodule

// ----- hw/rtl/cppc_checker.sv -----
// ----------------------------------------------------------------------------
// cppc_checker
// port level checks of the convex polygon point classifier
// ----------------------------------------------------------------------------
module cppc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [cppc_pkg::PLACE_W-1:0]      placement,
  input logic                              store_full,
  input logic [cppc_pkg::EDGES_HELD_W-1:0] edges_held
);

  import cppc_pkg::*;

  // a transfer either starts a walk or gives its result next cycle
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("transfer neither started a walk nor gave a result");

  // the end of a walk always shows a result
  a_walk_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a dropped append only happens with a full store and never classifies
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && store_full |-> edges_held == EDGES_HELD_W'(MAX_EDGES))
    else $error("store full flagged below capacity");

  a_full_no_place: assert property (@(posedge clk) disable iff (rst)
    done && store_full |-> placement == PLACE_OUTSIDE)
    else $error("store full flagged on a classify");

endmodule

bind convex_polygon_point_classify cppc_checker u_checker (.*);
